>>> rtl/assert_macros.svh
// Assertion macros for the execute unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RV32EU_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define RV32EU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define RV32EU_ASSERT(label, clk, rst_n, expr)
`define RV32EU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/rv32eu_pkg.sv
// Types and constants shared by the execute unit modules.
`default_nettype none
package rv32eu_pkg;
	localparam int unsigned XLEN = 32;
	localparam int unsigned DIV_STEPS = XLEN;

	localparam logic [3:0] OPC_LUI    = 4'd0;
	localparam logic [3:0] OPC_AUIPC  = 4'd1;
	localparam logic [3:0] OPC_JAL    = 4'd2;
	localparam logic [3:0] OPC_JALR   = 4'd3;
	localparam logic [3:0] OPC_BRANCH = 4'd4;
	localparam logic [3:0] OPC_LOAD   = 4'd5;
	localparam logic [3:0] OPC_STORE  = 4'd6;
	localparam logic [3:0] OPC_OPIMM  = 4'd7;
	localparam logic [3:0] OPC_OP     = 4'd8;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;
	localparam logic [2:0] F3_SW  = 3'd2;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_BRANCH = 2'd1;
	localparam logic [1:0] ST_BAD_STORE  = 2'd2;
	localparam logic [1:0] ST_BAD_OP     = 2'd3;

	typedef struct packed {
		logic [3:0]        opcode;
		logic [2:0]        funct3;
		logic [6:0]        funct7;
		logic signed [31:0] imm_value;
		logic [31:0]       instr_pc;
		logic [31:0]       src_a;
		logic [31:0]       src_b;
		logic [4:0]        imm_shift;
		logic              has_dest;
	} in_t;

	typedef struct packed {
		logic        wb_valid;
		logic [31:0] wb_value;
		logic        redirect_valid;
		logic [31:0] redirect_pc;
		logic [31:0] mem_addr;
		logic        mem_read;
		logic        mem_write;
		logic [1:0]  mem_size;
		logic        load_signed;
		logic [31:0] store_data;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		logic        active;
		logic        neg;
		logic        zero;
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] dvs;
	} div_t;
endpackage
`default_nettype wire

>>> rtl/rv32eu_alu.sv
// First stage: decode, integer ALU, branch, address, multiply and divide setup.
`default_nettype none
module rv32eu_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid,
	input  wire rv32eu_pkg::in_t   data,
	output logic                   valid_s1,
	output rv32eu_pkg::out_t       res_s1,
	output rv32eu_pkg::div_t       div_s1
);
	rv32eu_pkg::out_t r;
	rv32eu_pkg::div_t d;
	logic [31:0] a, b, imm, pc, sum_ai, pc_imm, pc4;
	logic        take, lt_ab, ltu_ab;

	always_comb begin
		a = data.src_a;
		b = data.src_b;
		imm = data.imm_value;
		pc = data.instr_pc;
		sum_ai = a + imm;
		pc_imm = pc + imm;
		pc4 = pc + 32'd4;
		lt_ab = $signed(a) < $signed(b);
		ltu_ab = a < b;
		take = 1'b0;
		r = '0;
		d = '0;
		d.neg = a[31] ^ b[31];
		d.zero = (b == 32'd0);
		d.quo = a[31] ? (32'd0 - a) : a;
		d.dvs = b[31] ? (32'd0 - b) : b;
		case (data.opcode)
			rv32eu_pkg::OPC_LUI: begin
				r.wb_valid = data.has_dest;
				r.wb_value = imm;
			end
			rv32eu_pkg::OPC_AUIPC: begin
				r.wb_valid = data.has_dest;
				r.wb_value = pc_imm;
			end
			rv32eu_pkg::OPC_JAL: begin
				r.wb_valid = data.has_dest;
				r.wb_value = pc4;
				r.redirect_valid = 1'b1;
				r.redirect_pc = pc_imm;
			end
			rv32eu_pkg::OPC_JALR: begin
				r.wb_valid = data.has_dest;
				r.wb_value = pc4;
				r.redirect_valid = 1'b1;
				r.redirect_pc = {sum_ai[31:1], 1'b0};
			end
			rv32eu_pkg::OPC_BRANCH: begin
				case (data.funct3)
					rv32eu_pkg::F3_BEQ:  take = (a == b);
					rv32eu_pkg::F3_BNE:  take = (a != b);
					rv32eu_pkg::F3_BLT:  take = lt_ab;
					rv32eu_pkg::F3_BGE:  take = !lt_ab;
					rv32eu_pkg::F3_BLTU: take = ltu_ab;
					rv32eu_pkg::F3_BGEU: take = !ltu_ab;
					default: r.status = rv32eu_pkg::ST_BAD_BRANCH;
				endcase
				if (r.status == rv32eu_pkg::ST_OK) begin
					r.redirect_valid = 1'b1;
					r.redirect_pc = take ? pc_imm : pc4;
				end
			end
			rv32eu_pkg::OPC_LOAD: begin
				r.mem_addr = sum_ai;
				r.wb_valid = data.has_dest;
				case (data.funct3)
					rv32eu_pkg::F3_LB, rv32eu_pkg::F3_LH, rv32eu_pkg::F3_LW,
					rv32eu_pkg::F3_LBU, rv32eu_pkg::F3_LHU: begin
						r.mem_read = 1'b1;
						r.mem_size = data.funct3[1:0];
						r.load_signed = (data.funct3 <= rv32eu_pkg::F3_LH);
					end
					default: r.mem_read = 1'b0;
				endcase
			end
			rv32eu_pkg::OPC_STORE: begin
				r.mem_addr = sum_ai;
				if (data.funct3 <= rv32eu_pkg::F3_SW) begin
					r.mem_write = 1'b1;
					r.mem_size = data.funct3[1:0];
					r.store_data = b;
				end else begin
					r.status = rv32eu_pkg::ST_BAD_STORE;
				end
			end
			rv32eu_pkg::OPC_OPIMM: begin
				r.wb_valid = data.has_dest;
				case (data.funct3)
					rv32eu_pkg::F3_ADD:  r.wb_value = sum_ai;
					rv32eu_pkg::F3_SLL:  r.wb_value = a << data.imm_shift;
					rv32eu_pkg::F3_SLT:  r.wb_value = {31'd0, $signed(a) < $signed(imm)};
					rv32eu_pkg::F3_SLTU: r.wb_value = {31'd0, a < imm};
					rv32eu_pkg::F3_XOR:  r.wb_value = a ^ imm;
					rv32eu_pkg::F3_SR:
						r.wb_value = (data.funct7 == rv32eu_pkg::F7_ALT) ?
							32'($signed(a) >>> data.imm_shift) : (a >> data.imm_shift);
					rv32eu_pkg::F3_OR:   r.wb_value = a | imm;
					default:             r.wb_value = a & imm;
				endcase
			end
			rv32eu_pkg::OPC_OP: begin
				r.wb_valid = data.has_dest;
				case (data.funct3)
					rv32eu_pkg::F3_ADD: begin
						if (data.funct7 == rv32eu_pkg::F7_BASE) begin
							r.wb_value = a + b;
						end else if (data.funct7 == rv32eu_pkg::F7_ALT) begin
							r.wb_value = a - b;
						end else if (data.funct7 == rv32eu_pkg::F7_MULDIV) begin
							r.wb_value = a * b;
						end else begin
							r.wb_valid = 1'b0;
							r.status = rv32eu_pkg::ST_BAD_OP;
						end
					end
					rv32eu_pkg::F3_SLL:  r.wb_value = a << b[4:0];
					rv32eu_pkg::F3_SLT:  r.wb_value = {31'd0, lt_ab};
					rv32eu_pkg::F3_SLTU: r.wb_value = {31'd0, ltu_ab};
					rv32eu_pkg::F3_XOR: begin
						if (data.funct7 == rv32eu_pkg::F7_MULDIV) begin
							d.active = 1'b1;
						end else begin
							r.wb_value = a ^ b;
						end
					end
					rv32eu_pkg::F3_SR:
						r.wb_value = (data.funct7 == rv32eu_pkg::F7_ALT) ?
							32'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
					rv32eu_pkg::F3_OR:   r.wb_value = a | b;
					default:             r.wb_value = a & b;
				endcase
			end
			default: r.status = rv32eu_pkg::ST_BAD_OP;
		endcase
		if (!r.wb_valid) begin
			r.wb_value = '0;
			d.active = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= r;
			div_s1 <= d;
		end
	end
endmodule
`default_nettype wire

>>> rtl/rv32eu_div_step.sv
// One restoring divide step with its pipeline register and the carried result.
`default_nettype none
module rv32eu_div_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid,
	input  wire rv32eu_pkg::out_t  res,
	input  wire rv32eu_pkg::div_t  div,
	output logic                   valid_s1,
	output rv32eu_pkg::out_t       res_s1,
	output rv32eu_pkg::div_t       div_s1
);
	logic [32:0] trial;
	logic [32:0] diff;
	rv32eu_pkg::div_t nxt;

	always_comb begin
		nxt = div;
		trial = {div.rem, div.quo[31]};
		diff = trial - {1'b0, div.dvs};
		if (!diff[32]) begin
			nxt.rem = diff[31:0];
			nxt.quo = {div.quo[30:0], 1'b1};
		end else begin
			nxt.rem = trial[31:0];
			nxt.quo = {div.quo[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= res;
			div_s1 <= nxt;
		end
	end
endmodule
`default_nettype wire

>>> rtl/rv32_execute_unit.sv
// Top level of the pipelined RV32 integer execute unit.
// The unit takes one micro-op per cycle while in_ready is high and passes each
// result to the output through 34 register stages: one decode and ALU stage,
// 32 divide stages (one quotient bit each, which every op passes through so
// results stay in order) and an output stage that fixes the quotient sign. The
// whole pipeline holds while a result waits at the output and advances as soon
// as it is taken, so in_ready follows out_ready in the same cycle.
`default_nettype none
`include "assert_macros.svh"
module rv32_execute_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rv32eu_pkg::in_t   in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rv32eu_pkg::out_t       out_data
);
	localparam int unsigned N = rv32eu_pkg::DIV_STEPS;

	logic                 en;
	logic                 vld [0:N];
	rv32eu_pkg::out_t     res [0:N];
	rv32eu_pkg::div_t     dv  [0:N];
	logic                 valid_s34;
	rv32eu_pkg::out_t     data_s34;
	rv32eu_pkg::out_t     fin;

	assign en = !valid_s34 || out_ready;
	assign in_ready = en;

	rv32eu_alu u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (in_valid),
		.data     (in_data),
		.valid_s1 (vld[0]),
		.res_s1   (res[0]),
		.div_s1   (dv[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_div
		rv32eu_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid    (vld[i]),
			.res      (res[i]),
			.div      (dv[i]),
			.valid_s1 (vld[i+1]),
			.res_s1   (res[i+1]),
			.div_s1   (dv[i+1])
		);
	end

	always_comb begin
		fin = res[N];
		if (dv[N].active) begin
			if (dv[N].zero) begin
				fin.wb_value = '1;
			end else if (dv[N].neg) begin
				fin.wb_value = 32'd0 - dv[N].quo;
			end else begin
				fin.wb_value = dv[N].quo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s34 <= 1'b0;
		end else if (en) begin
			valid_s34 <= vld[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s34 <= fin;
		end
	end

	assign out_valid = valid_s34;
	assign out_data = data_s34;

	`RV32EU_ASSERT(a_ready_follows_out, clk, arst_n, in_ready == (!out_valid || out_ready))
	`RV32EU_ASSERT_IMP(a_one_access, clk, arst_n, out_valid, !(out_data.mem_read && out_data.mem_write))
	`RV32EU_ASSERT_IMP(a_wb_zero, clk, arst_n, out_valid && !out_data.wb_valid, out_data.wb_value == 32'd0)
	`RV32EU_ASSERT_IMP(a_redirect_no_mem, clk, arst_n, out_valid && out_data.redirect_valid, !out_data.mem_read && !out_data.mem_write)
endmodule
`default_nettype wire
